// ===== rtl/ecal_pkg.sv =====
// Shared constants for the epoch-seconds to calendar converter.
package ecal_pkg;

    // Field widths of the request and result.
    localparam int SECONDS_W = 32;
    localparam int YEAR_W    = 8;
    localparam int MONTH_W   = 4;
    localparam int MDAY_W    = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;

    // Internal widths.
    localparam int DAYS_W  = 16;   // whole days, at most 49710
    localparam int FRAC_W  = 17;   // seconds within a day, below 86400
    localparam int MINS_W  = 11;   // minutes within a day, below 1440
    localparam int REM_W   = 16;   // days within a century, below 36525
    localparam int QUAD_W  = 5;    // four-year blocks within a century, below 25
    localparam int DREM_W  = 11;   // days within a four-year block, below 1461
    localparam int DOY_W   = 9;    // day of year, below 366

    // 86400 = 2^7 * 675: the low seven bits pass through, the rest divides by 675.
    localparam int          SEC_LOW_W       = 7;
    localparam int          SEC_HIGH_W      = SECONDS_W - SEC_LOW_W;
    localparam logic [9:0]  DAY_ODD         = 10'd675;
    localparam logic [25:0] DAY_RECIP       = 26'd50903317;   // ceil(2^35 / 675)
    localparam int          DAY_RECIP_SHIFT = 35;

    // Divide by 60 for seconds within a day and for minutes within a day.
    localparam logic [17:0] MIN_RECIP        = 18'd139811;    // ceil(2^23 / 60)
    localparam int          MIN_RECIP_SHIFT  = 23;
    localparam logic [11:0] HOUR_RECIP       = 12'd2185;      // ceil(2^17 / 60)
    localparam int          HOUR_RECIP_SHIFT = 17;

    // Gregorian cycle lengths in days.
    localparam logic [15:0] DAYS_PER_CENTURY = 16'd36525;
    localparam logic [10:0] DAYS_PER_QUAD    = 11'd1461;
    localparam logic [16:0] QUAD_RECIP       = 17'd91868;     // ceil(2^27 / 1461)
    localparam int          QUAD_RECIP_SHIFT = 27;
    localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;
    localparam logic [7:0]  CENTURY_YEARS    = 8'd100;

    // Month pattern from March on: 153 days per five months, 61 per two, 31 per one.
    localparam logic [8:0] DAYS_5_MONTHS = 9'd153;
    localparam logic [8:0] DAYS_2_MONTHS = 9'd61;
    localparam logic [8:0] DAYS_1_MONTH  = 9'd31;
    localparam logic [8:0] FEB_END       = 9'd59;
    localparam logic [3:0] MONTH_MARCH   = 4'd2;

    // Pipeline depths.
    localparam int SPLIT_STAGES = 2;
    localparam int PATH_STAGES  = 5;
    localparam int LATENCY      = SPLIT_STAGES + PATH_STAGES;

endpackage

// ===== rtl/ecal_day_split.sv =====
// Two-stage split of the seconds count into whole days and seconds within the day.
module ecal_day_split
    import ecal_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [SECONDS_W-1:0] i_seconds,
    output logic                 o_valid,
    output logic [DAYS_W-1:0]    o_days,
    output logic [FRAC_W-1:0]    o_frac
);

    logic                  r_valid_a;
    logic [DAYS_W-1:0]     r_days_a;
    logic [SEC_HIGH_W-1:0] r_high_a;
    logic [SEC_LOW_W-1:0]  r_low_a;
    logic                  r_valid_b;
    logic [DAYS_W-1:0]     r_days_b;
    logic [FRAC_W-1:0]     r_frac_b;

    logic [SEC_HIGH_W+26-1:0] n_day_prod;
    logic [DAYS_W-1:0]        n_days;
    logic [SEC_HIGH_W-1:0]    n_day_base;
    logic [SEC_HIGH_W-1:0]    n_frac_high;

    // Stage A: days = (seconds / 128) / 675 by a reciprocal multiply.
    always_comb begin
        n_day_prod = (SEC_HIGH_W+26)'(i_seconds[SECONDS_W-1:SEC_LOW_W])
                   * (SEC_HIGH_W+26)'(DAY_RECIP);
        n_days     = n_day_prod[DAY_RECIP_SHIFT +: DAYS_W];
    end

    // Stage B: the remainder rebuilt from the high part and the untouched low bits.
    always_comb begin
        n_day_base  = SEC_HIGH_W'(r_days_a) * SEC_HIGH_W'(DAY_ODD);
        n_frac_high = r_high_a - n_day_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_days_a <= n_days;
        r_high_a <= i_seconds[SECONDS_W-1:SEC_LOW_W];
        r_low_a  <= i_seconds[SEC_LOW_W-1:0];
        r_days_b <= r_days_a;
        r_frac_b <= {n_frac_high[FRAC_W-SEC_LOW_W-1:0], r_low_a};
    end

    assign o_valid = r_valid_b;
    assign o_days  = r_days_b;
    assign o_frac  = r_frac_b;

endmodule

// ===== rtl/ecal_tod.sv =====
// Five-stage time-of-day path: seconds within a day to hour, minute and second.
module ecal_tod
    import ecal_pkg::*;
(
    input  logic                i_clk,
    input  logic [FRAC_W-1:0]   i_frac,
    output logic [HOUR_W-1:0]   o_hour,
    output logic [MINUTE_W-1:0] o_minute,
    output logic [SECOND_W-1:0] o_second
);

    logic [FRAC_W-1:0]   r_frac_1;
    logic [MINS_W-1:0]   r_mins_1;
    logic [MINS_W-1:0]   r_mins_2;
    logic [HOUR_W-1:0]   r_hour_2;
    logic [SECOND_W-1:0] r_sec_2;
    logic [HOUR_W-1:0]   r_hour_3;
    logic [MINUTE_W-1:0] r_min_3;
    logic [SECOND_W-1:0] r_sec_3;
    logic [HOUR_W-1:0]   r_hour_4;
    logic [MINUTE_W-1:0] r_min_4;
    logic [SECOND_W-1:0] r_sec_4;
    logic [HOUR_W-1:0]   r_hour_5;
    logic [MINUTE_W-1:0] r_min_5;
    logic [SECOND_W-1:0] r_sec_5;

    logic [FRAC_W+18-1:0] n_min_prod;
    logic [MINS_W+12-1:0] n_hour_prod;
    logic [FRAC_W-1:0]    n_sec_full;
    logic [MINS_W-1:0]    n_min_full;

    // Stage 1: minutes within the day.
    always_comb begin
        n_min_prod = (FRAC_W+18)'(i_frac) * (FRAC_W+18)'(MIN_RECIP);
    end

    // Stage 2: second from the minute remainder, hour from the minutes.
    always_comb begin
        n_sec_full  = r_frac_1 - FRAC_W'({r_mins_1, 6'd0} - {r_mins_1, 2'd0});
        n_hour_prod = (MINS_W+12)'(r_mins_1) * (MINS_W+12)'(HOUR_RECIP);
    end

    // Stage 3: minute within the hour.
    always_comb begin
        n_min_full = r_mins_2 - MINS_W'({r_hour_2, 6'd0} - {r_hour_2, 2'd0});
    end

    // Stages 4 and 5 line the time up with the date path.
    always_ff @(posedge i_clk) begin
        r_frac_1 <= i_frac;
        r_mins_1 <= n_min_prod[MIN_RECIP_SHIFT +: MINS_W];
        r_mins_2 <= r_mins_1;
        r_sec_2  <= n_sec_full[SECOND_W-1:0];
        r_hour_2 <= n_hour_prod[HOUR_RECIP_SHIFT +: HOUR_W];
        r_hour_3 <= r_hour_2;
        r_min_3  <= n_min_full[MINUTE_W-1:0];
        r_sec_3  <= r_sec_2;
        r_hour_4 <= r_hour_3;
        r_min_4  <= r_min_3;
        r_sec_4  <= r_sec_3;
        r_hour_5 <= r_hour_4;
        r_min_5  <= r_min_4;
        r_sec_5  <= r_sec_4;
    end

    assign o_hour   = r_hour_5;
    assign o_minute = r_min_5;
    assign o_second = r_sec_5;

endmodule

// ===== rtl/ecal_date.sv =====
// Five-stage date path: whole days since 2000-01-01 to year, month and day of month.
module ecal_date
    import ecal_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [DAYS_W-1:0]  i_days,
    output logic               o_valid,
    output logic [YEAR_W-1:0]  o_year,
    output logic [MONTH_W-1:0] o_month,
    output logic [MDAY_W-1:0]  o_mday
);

    logic [PATH_STAGES-1:0] r_valid;

    logic               r_cent_1;
    logic [REM_W-1:0]   r_rem_1;
    logic               r_cent_2;
    logic [REM_W-1:0]   r_rem_2;
    logic [QUAD_W-1:0]  r_quad_2;
    logic [YEAR_W-1:0]  r_year_3;
    logic [DREM_W-1:0]  r_drem_3;
    logic [YEAR_W-1:0]  r_year_4;
    logic [DOY_W-1:0]   r_doy_4;
    logic               r_leap_4;
    logic [YEAR_W-1:0]  r_year_5;
    logic [MONTH_W-1:0] r_month_5;
    logic [MDAY_W-1:0]  r_mday_5;

    logic                    n_cent;
    logic [REM_W-1:0]        n_rem;
    logic [REM_W+17-1:0]     n_quad_prod;
    logic [DREM_W-1:0]       n_drem;
    logic [YEAR_W-1:0]       n_year_3;
    logic [DREM_W-1:0]       n_dd;
    logic [DREM_W-1:0]       n_dd_adj;
    logic                    n_leap;
    logic                    n_leap_4;
    logic [2:0]              n_yq;
    logic [YEAR_W-1:0]       n_year_4;
    logic [DREM_W-1:0]       n_doy_full;
    logic [DOY_W-1:0]        n_febend;
    logic [DOY_W-1:0]        n_r;
    logic                    n_q153;
    logic [DOY_W-1:0]        n_r1;
    logic [1:0]              n_q61;
    logic [DOY_W-1:0]        n_r2;
    logic                    n_q31;
    logic [MONTH_W-1:0]      n_month;
    logic [DOY_W-1:0]        n_mday;

    // Stage 1: which century, and the day within it.
    always_comb begin
        n_cent = (i_days >= DAYS_PER_CENTURY);
        n_rem  = n_cent ? (i_days - DAYS_PER_CENTURY) : i_days;
    end

    // Stage 2: four-year block within the century by a reciprocal multiply.
    always_comb begin
        n_quad_prod = (REM_W+17)'(r_rem_1) * (REM_W+17)'(QUAD_RECIP);
    end

    // Stage 3: day within the block and the year at the start of the block.
    always_comb begin
        n_drem   = DREM_W'(r_rem_2 - REM_W'(r_quad_2) * REM_W'(DAYS_PER_QUAD));
        n_year_3 = (r_cent_2 ? CENTURY_YEARS : '0) + YEAR_W'({r_quad_2, 2'b00});
    end

    // Stage 4: the 2100 shift, then the year within the block by compares against 365.
    always_comb begin
        n_dd     = r_drem_3 + DREM_W'(r_year_3 > CENTURY_YEARS);
        n_leap   = (r_year_3 != CENTURY_YEARS);
        n_leap_4 = n_leap;
        n_yq     = '0;
        n_dd_adj = n_dd;
        if (n_dd > DREM_W'(364) + DREM_W'(n_leap)) begin
            n_dd_adj = n_dd - DREM_W'(n_leap);
            n_leap_4 = 1'b0;
            if (n_dd_adj >= DREM_W'(4) * DREM_W'(DAYS_PER_YEAR)) begin
                n_yq = 3'd4;
            end else if (n_dd_adj >= DREM_W'(3) * DREM_W'(DAYS_PER_YEAR)) begin
                n_yq = 3'd3;
            end else if (n_dd_adj >= DREM_W'(2) * DREM_W'(DAYS_PER_YEAR)) begin
                n_yq = 3'd2;
            end else if (n_dd_adj >= DREM_W'(DAYS_PER_YEAR)) begin
                n_yq = 3'd1;
            end
        end
        n_doy_full = n_dd_adj - DREM_W'(n_yq) * DREM_W'(DAYS_PER_YEAR);
        n_year_4   = r_year_3 + YEAR_W'(n_yq);
    end

    // Stage 5: month and day, January and February apart, then the 153/61/31 pattern.
    always_comb begin
        n_febend = FEB_END + DOY_W'(r_leap_4);
        n_r      = '0;
        n_q153   = 1'b0;
        n_r1     = '0;
        n_q61    = '0;
        n_r2     = '0;
        n_q31    = 1'b0;
        if (r_doy_4 < n_febend) begin
            n_q31   = (r_doy_4 >= DAYS_1_MONTH);
            n_month = MONTH_W'(n_q31);
            n_mday  = r_doy_4 - (n_q31 ? DAYS_1_MONTH : '0);
        end else begin
            n_r    = r_doy_4 - n_febend;
            n_q153 = (n_r >= DAYS_5_MONTHS);
            n_r1   = n_r - (n_q153 ? DAYS_5_MONTHS : '0);
            if (n_r1 >= DOY_W'(2) * DAYS_2_MONTHS) begin
                n_q61 = 2'd2;
            end else if (n_r1 >= DAYS_2_MONTHS) begin
                n_q61 = 2'd1;
            end
            n_r2    = n_r1 - DOY_W'(n_q61) * DAYS_2_MONTHS;
            n_q31   = (n_r2 >= DAYS_1_MONTH);
            n_mday  = n_r2 - (n_q31 ? DAYS_1_MONTH : '0);
            n_month = MONTH_MARCH + (n_q153 ? MONTH_W'(5) : '0)
                    + MONTH_W'({n_q61, 1'b0}) + MONTH_W'(n_q31);
        end
    end

    // Valid bits travel alongside the date stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[PATH_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cent_1  <= n_cent;
        r_rem_1   <= n_rem;
        r_cent_2  <= r_cent_1;
        r_rem_2   <= r_rem_1;
        r_quad_2  <= n_quad_prod[QUAD_RECIP_SHIFT +: QUAD_W];
        r_year_3  <= n_year_3;
        r_drem_3  <= n_drem;
        r_year_4  <= n_year_4;
        r_doy_4   <= n_doy_full[DOY_W-1:0];
        r_leap_4  <= n_leap_4;
        r_year_5  <= r_year_4;
        r_month_5 <= n_month;
        r_mday_5  <= n_mday[MDAY_W-1:0];
    end

    assign o_valid = r_valid[PATH_STAGES-1];
    assign o_year  = r_year_5;
    assign o_month = r_month_5;
    assign o_mday  = r_mday_5;

endmodule

// ===== rtl/epoch_seconds_to_calendar_core.sv =====
// Top level of the epoch-seconds to calendar converter.
//
// A request is a 32-bit count of seconds since 2000-01-01 00:00:00. It is taken
// at a rising clock edge where start is high and busy is low. busy never rises,
// so a new request may be given in every cycle.
// Each request yields one result: year minus 2000, zero-based month, zero-based
// day of month, hour, minute and second. The result sits on the o_ ports for
// exactly one cycle, marked by o_valid, once the request has left the last stage.
// The pipeline has seven register stages: two split seconds into days and the
// time within the day, then five run the date and time paths side by side.
// Throughput is one result per cycle; each stage holds at most one request.
// The receiver cannot hold results off, so the pipeline never stalls.
// Synchronous reset (i_rst_n low) clears all valid bits, dropping requests in
// flight; no result appears until a request is taken after reset.
module epoch_seconds_to_calendar_core
    import ecal_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [SECONDS_W-1:0] i_seconds_since_2000,
    output logic                 o_valid,
    output logic [YEAR_W-1:0]    o_year_offset,
    output logic [MONTH_W-1:0]   o_month_index,
    output logic [MDAY_W-1:0]    o_day_index,
    output logic [HOUR_W-1:0]    o_hour_of_day,
    output logic [MINUTE_W-1:0]  o_minute_of_hour,
    output logic [SECOND_W-1:0]  o_second_of_minute
);

    logic              split_valid;
    logic [DAYS_W-1:0] split_days;
    logic [FRAC_W-1:0] split_frac;
    logic              take;

    // The pipeline moves every cycle, so a request is always taken.
    assign busy = 1'b0;
    assign take = start && !busy;

    // Days and time within the day.
    ecal_day_split u_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (take),
        .i_seconds (i_seconds_since_2000),
        .o_valid   (split_valid),
        .o_days    (split_days),
        .o_frac    (split_frac)
    );

    // Hour, minute and second.
    ecal_tod u_tod (
        .i_clk    (i_clk),
        .i_frac   (split_frac),
        .o_hour   (o_hour_of_day),
        .o_minute (o_minute_of_hour),
        .o_second (o_second_of_minute)
    );

    // Year, month and day; carries the result strobe.
    ecal_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .i_days  (split_days),
        .o_valid (o_valid),
        .o_year  (o_year_offset),
        .o_month (o_month_index),
        .o_mday  (o_day_index)
    );

    // Every request gives its result after the full pipeline depth.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##LATENCY o_valid)
        else $error("Request did not produce a result after the pipeline depth.");

    // No result without a request the pipeline depth earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(take, LATENCY))
        else $error("Result strobe without a matching request.");

    // Calendar fields stay inside their ranges.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year_offset <= YEAR_W'(136)) && (o_month_index <= MONTH_W'(11))
                    && (o_day_index <= MDAY_W'(30)))
        else $error("Date field out of range.");

    // Time fields stay inside their ranges.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour_of_day <= HOUR_W'(23)) && (o_minute_of_hour <= MINUTE_W'(59))
                    && (o_second_of_minute <= SECOND_W'(59)))
        else $error("Time field out of range.");

endmodule
